// ===== rtl/lpwp_pkg.sv =====
// Shared constants and types for the lidar ping to world point block.
package lpwp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_RANGE_LIMIT = 3'd0;
  localparam logic [2:0] REG_START_ANGLE = 3'd1;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd2;
  localparam logic [2:0] REG_ROT_COL_X   = 3'd3;
  localparam logic [2:0] REG_ROT_COL_Y   = 3'd4;
  localparam logic [2:0] REG_TRANSLATION = 3'd5;

  // Reset values
  localparam logic [15:0] RST_RANGE_LIMIT = 16'd5000;
  localparam logic [15:0] RST_START_ANGLE = 16'd49152;
  localparam logic [15:0] RST_ANGLE_STEP  = 16'd182;
  localparam logic [47:0] RST_ROT_COL_X   = 48'd16384;
  localparam logic [47:0] RST_ROT_COL_Y   = 48'd1073741824;
  localparam logic [47:0] RST_TRANSLATION = 48'd0;

  // Quarter-wave sine polynomial, Q24 coefficients
  localparam logic [24:0] SIN_C1 = 25'd26353589;
  localparam logic [24:0] SIN_C3 = 25'd10837479;
  localparam logic [24:0] SIN_C5 = 25'd1337020;
  localparam logic [24:0] SIN_C7 = 25'd78547;
  localparam logic [24:0] SIN_C9 = 25'd2692;

  localparam logic [14:0] QUARTER_TURN = 15'd16384;

  localparam logic signed [19:0] SAT_HI = 20'sd524287;
  localparam logic signed [19:0] SAT_LO = -20'sd524288;

  // Data moved from one Horner cell to the next
  typedef struct packed {
    logic        vld;
    logic        lane;  // 0: sine term, 1: cosine term
    logic [14:0] u;
    logic [28:0] u2;
    logic [24:0] t;
  } lpwp_cell_t;

endpackage

// ===== rtl/lpwp_horner_cell.sv =====
// One Horner step of the sine polynomial: t_out = COEF - (t * u^2 >> 28).
module lpwp_horner_cell import lpwp_pkg::*; #(
  parameter logic [24:0] COEF = SIN_C7
) (
  input  logic       clk,
  input  logic       rst,
  input  lpwp_cell_t din,
  output lpwp_cell_t dout
);

  logic [53:0] prod;

  assign prod = {29'd0, din.t} * {25'd0, din.u2};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.lane <= din.lane;
    dout.u    <= din.u;
    dout.u2   <= din.u2;
    dout.t    <= COEF - prod[52:28];
  end

endmodule

// ===== rtl/lidar_ping_to_world_point.sv =====
// Lidar ping to world point: top level.
// Each accepted ping gets its binary angle (restarted at start_angle on the first ping of
// a scan, then stepped by angle_step), is turned into lidar x/y with a fixed-point sine
// and cosine, rotated by two Q2.14 columns, translated and saturated to 20-bit world
// coordinates. Sine and cosine go one after the other through a row of four Horner cells;
// the three world axes are then formed one at a time by a shared multiply/add pair. From
// acceptance a ping passes two feed states, waits in the trig state through the cell row
// and the sine/cosine capture, takes one state for lidar x/y, a multiply and an add state
// per axis, and ends in the output state. in_stall is high until the result is loaded into
// the output register, so no new ping is taken before that; the next ping is taken while
// the previous result still waits for the receiver, and it holds in its output state until
// that result has gone.
module lidar_ping_to_world_point import lpwp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        range_mm,
  input  logic               first_of_scan,
  input  logic               last_of_scan,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] world_x_mm,
  output logic signed [19:0] world_y_mm,
  output logic signed [19:0] world_z_mm,
  output logic               point_valid,
  output logic               end_of_scan
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FEED0 = 3'd1;
  localparam logic [2:0] ST_FEED1 = 3'd2;
  localparam logic [2:0] ST_TRIG  = 3'd3;
  localparam logic [2:0] ST_CART  = 3'd4;
  localparam logic [2:0] ST_MUL   = 3'd5;
  localparam logic [2:0] ST_ADD   = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]  state;
  logic [15:0] range_limit, start_angle, angle_step, ping_angle;
  logic [47:0] rot_col_x, rot_col_y, translation;

  logic [15:0] range_r, ang;
  logic        last_r, pvalid_r;
  logic [14:0] s_val, c_val;
  logic signed [15:0] sn, cs;
  logic signed [31:0] lx, ly;
  logic signed [47:0] px, py;
  logic [1:0]  axis;
  logic signed [19:0] world [3];

  lpwp_cell_t sq;
  lpwp_cell_t chain [5];

  logic        accept;
  logic        out_load;
  logic [15:0] ang_sel;
  logic [40:0] fin_prod;
  logic [14:0] fin_r;
  logic [14:0] u_c;
  logic signed [48:0] acc;
  logic signed [20:0] rnd;
  logic signed [21:0] wsum;
  logic signed [19:0] wsat;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ang_sel  = first_of_scan ? start_angle : ping_angle;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // Configuration and angle state
  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit <= RST_RANGE_LIMIT;
      start_angle <= RST_START_ANGLE;
      angle_step  <= RST_ANGLE_STEP;
      rot_col_x   <= RST_ROT_COL_X;
      rot_col_y   <= RST_ROT_COL_Y;
      translation <= RST_TRANSLATION;
      ping_angle  <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RANGE_LIMIT: range_limit <= cfg_data[15:0];
          REG_START_ANGLE: start_angle <= cfg_data[15:0];
          REG_ANGLE_STEP:  angle_step  <= cfg_data[15:0];
          REG_ROT_COL_X:   rot_col_x   <= cfg_data;
          REG_ROT_COL_Y:   rot_col_y   <= cfg_data;
          REG_TRANSLATION: translation <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        ping_angle <= ang_sel + angle_step;
      end
    end
  end

  // Square stage feeding the cell row
  assign u_c = QUARTER_TURN - {1'b0, ang[13:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq.vld <= 1'b0;
    end else begin
      sq.vld <= (state == ST_FEED0) || (state == ST_FEED1);
    end
    sq.t <= SIN_C9;
    if (state == ST_FEED0) begin
      sq.lane <= 1'b0;
      sq.u    <= {1'b0, ang[13:0]};
      sq.u2   <= {15'd0, ang[13:0]} * {15'd0, ang[13:0]};
    end else begin
      sq.lane <= 1'b1;
      sq.u    <= u_c;
      sq.u2   <= {14'd0, u_c} * {14'd0, u_c};
    end
  end

  assign chain[0] = sq;

  lpwp_horner_cell #(.COEF(SIN_C7)) u_cell7 (.clk, .rst, .din(chain[0]), .dout(chain[1]));
  lpwp_horner_cell #(.COEF(SIN_C5)) u_cell5 (.clk, .rst, .din(chain[1]), .dout(chain[2]));
  lpwp_horner_cell #(.COEF(SIN_C3)) u_cell3 (.clk, .rst, .din(chain[2]), .dout(chain[3]));
  lpwp_horner_cell #(.COEF(SIN_C1)) u_cell1 (.clk, .rst, .din(chain[3]), .dout(chain[4]));

  // Final polynomial step with rounding and cap at one
  assign fin_prod = {16'd0, chain[4].t} * {26'd0, chain[4].u} + 41'd8388608;
  assign fin_r    = (fin_prod[40:24] > 17'd16384) ? QUARTER_TURN : fin_prod[38:24];

  always_ff @(posedge clk) begin
    if (chain[4].vld) begin
      if (chain[4].lane) begin
        c_val <= fin_r;
      end else begin
        s_val <= fin_r;
      end
    end
  end

  // Quadrant folding
  always_comb begin
    case (ang[15:14])
      2'd0: begin sn =  $signed({1'b0, s_val}); cs =  $signed({1'b0, c_val}); end
      2'd1: begin sn =  $signed({1'b0, c_val}); cs = -$signed({1'b0, s_val}); end
      2'd2: begin sn = -$signed({1'b0, s_val}); cs = -$signed({1'b0, c_val}); end
      default: begin sn = -$signed({1'b0, c_val}); cs = $signed({1'b0, s_val}); end
    endcase
  end

  // Axis arithmetic: rounding shift is a plain arithmetic shift of v + 2^27
  assign acc  = 49'(px) + 49'(py) + 49'sd134217728;
  assign rnd  = acc[48:28];
  assign wsum = 22'(rnd) + 22'($signed(translation[16*axis +: 16]));
  assign wsat = (wsum > 22'(SAT_HI)) ? SAT_HI :
                (wsum < 22'(SAT_LO)) ? SAT_LO : wsum[19:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      axis      <= 2'd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_FEED0;
          end
        end
        ST_FEED0: state <= ST_FEED1;
        ST_FEED1: state <= ST_TRIG;
        ST_TRIG: begin
          if (chain[4].vld && chain[4].lane) begin
            state <= ST_CART;
          end
        end
        ST_CART: begin
          axis  <= 2'd0;
          state <= ST_MUL;
        end
        ST_MUL: state <= ST_ADD;
        ST_ADD: begin
          if (axis == 2'd2) begin
            state <= ST_OUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      range_r  <= range_mm;
      ang      <= ang_sel;
      last_r   <= last_of_scan;
      pvalid_r <= range_mm < range_limit;
    end
    if (state == ST_CART) begin
      lx <= 32'($signed({1'b0, range_r}) * cs);
      ly <= 32'($signed({1'b0, range_r}) * sn);
    end
    if (state == ST_MUL) begin
      px <= lx * $signed(rot_col_x[16*axis +: 16]);
      py <= ly * $signed(rot_col_y[16*axis +: 16]);
    end
    if (state == ST_ADD) begin
      world[axis] <= wsat;
    end
    if (out_load) begin
      world_x_mm  <= pvalid_r ? world[0] : 20'sd0;
      world_y_mm  <= pvalid_r ? world[1] : 20'sd0;
      world_z_mm  <= pvalid_r ? world[2] : 20'sd0;
      point_valid <= pvalid_r;
      end_of_scan <= last_r;
    end
  end

endmodule

// ===== rtl/lpwp_checker.sv =====
// Port-level checks for the lidar ping to world point block, with its bind.
module lpwp_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [47:0]        cfg_data,
  input logic               in_valid,
  input logic               in_stall,
  input logic [15:0]        range_mm,
  input logic               first_of_scan,
  input logic               last_of_scan,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [19:0] world_x_mm,
  input logic signed [19:0] world_y_mm,
  input logic signed [19:0] world_z_mm,
  input logic               point_valid,
  input logic               end_of_scan
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One ping in flight: after a transaction the input side stalls
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second ping taken while one is in flight");

  // Discarded points carry zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |->
      world_x_mm == 20'sd0 && world_y_mm == 20'sd0 && world_z_mm == 20'sd0)
    else $error("invalid point with nonzero coordinates");

  // Nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind lidar_ping_to_world_point lpwp_checker u_lpwp_checker (.*);
